// ----- rtl/core/nvs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nvs_pkg;

  localparam int INDEX_WIDTH      = 12;
  localparam int COUNT_WIDTH      = 13;
  localparam int COORD_PORT_WIDTH = 24;
  localparam int DIST_WIDTH       = 50;

  // request opcodes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // saturation limit of every squared term and of the sum
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

  typedef struct packed {
    logic                               cmd;
    logic [INDEX_WIDTH-1:0]             vertex_index;
    logic signed [COORD_PORT_WIDTH-1:0] coord_x;
    logic signed [COORD_PORT_WIDTH-1:0] coord_y;
    logic signed [COORD_PORT_WIDTH-1:0] coord_z;
  } nvs_req_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] nearest_index;
    logic [DIST_WIDTH-1:0]  nearest_distance_sq;
  } nvs_res_t;

  // controller to datapath
  typedef struct packed {
    logic load_query;
    logic write_vertex;
    logic read_vertex;
    logic read_first;
  } nvs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_empty;
  } nvs_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/nearest_vertex_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                    payload
// request   in         start high while busy low    request (nvs_req_t)
// result    out        done high for one cycle      result  (nvs_res_t)
// config    in         cfg_valid and cfg_ready      cfg_data (vertex_count)
//
// a write request leaves busy low
// a query request holds busy while n entries are scanned, n being vertex_count
// clamped to 1..MAX_VERTICES, and while the pipeline drains; then done shows
// the result for one cycle; the scan uses the single read port of the vertex
// store, one entry per cycle into a five-stage distance pipeline
// synchronous reset sets vertex_count to 1; the store is not cleared
// a new request may be taken in the cycle that done is high; the result
// receiver cannot stall, cfg_ready is always high

module nearest_vertex_search
  import nvs_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int COORD_WIDTH  = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire nvs_req_t               request,
  output logic                        busy,
  output logic                        done,
  output nvs_res_t                    result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [COUNT_WIDTH-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_VERTICES);

  nvs_cmd_t    cmd;
  nvs_status_t status;
  logic [AW-1:0] rd_addr;

  // register write is a single flop update, never held off
  assign cfg_ready = 1'b1;

  // sequencer: request decode, scan address, drain and result strobe
  nvs_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .status   (status)
  );

  // vertex store, distance pipeline and running minimum
  nvs_datapath #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .cmd    (cmd),
    .rd_addr(rd_addr),
    .status (status),
    .result (result)
  );

endmodule

`default_nettype wire

// ----- rtl/core/nvs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nvs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nvs_ctrl
  import nvs_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire nvs_req_t               request,
  output logic                        busy,
  output logic                        done,
  input  wire logic                   cfg_valid,
  input  wire logic [COUNT_WIDTH-1:0] cfg_data,
  output nvs_cmd_t                    cmd,
  output logic      [AW-1:0]          rd_addr,
  input  wire nvs_status_t            status
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [AW-1:0]          addr, addr_next;
  logic [AW-1:0]          last_addr, last_addr_next;
  logic [COUNT_WIDTH-1:0] vertex_count;
  logic [31:0]            count_wide;
  logic [31:0]            scan_len;
  logic                   accept;
  logic                   index_ok;

  // clamp count to 1..MAX_VERTICES
  always_comb begin
    count_wide = 32'(vertex_count);
    if (count_wide == 32'd0) begin
      scan_len = 32'd1;
    end else if (count_wide > 32'(MAX_VERTICES)) begin
      scan_len = 32'(MAX_VERTICES);
    end else begin
      scan_len = count_wide;
    end
  end

  assign index_ok = 32'(request.vertex_index) < 32'(MAX_VERTICES);
  assign busy     = (state == ST_SCAN) || (state == ST_DRAIN);
  assign done     = (state == ST_DONE);
  assign accept   = start && !busy;
  assign rd_addr  = addr;

  always_comb begin
    state_next     = state;
    addr_next      = addr;
    last_addr_next = last_addr;
    cmd            = '0;
    unique case (state)
      ST_IDLE, ST_DONE: begin
        state_next = ST_IDLE;
        if (accept) begin
          if (request.cmd == CMD_QUERY) begin
            cmd.load_query = 1'b1;
            addr_next      = '0;
            last_addr_next = AW'(scan_len - 32'd1);
            state_next     = ST_SCAN;
          end else begin
            cmd.write_vertex = index_ok;
          end
        end
      end
      ST_SCAN: begin
        cmd.read_vertex = 1'b1;
        cmd.read_first  = (addr == '0);
        addr_next       = addr + AW'(1);
        if (addr == last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_next = ST_DONE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= COUNT_WIDTH'(1);
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        vertex_count <= cfg_data;
      end
    end
    addr      <= addr_next;
    last_addr <= last_addr_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/nvs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nvs_datapath
  import nvs_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int COORD_WIDTH  = 24,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire nvs_req_t    request,
  input  wire nvs_cmd_t    cmd,
  input  wire logic [AW-1:0] rd_addr,
  output nvs_status_t      status,
  output nvs_res_t         result
);

  localparam int CW  = COORD_WIDTH;
  localparam int RW  = (CW > COORD_PORT_WIDTH) ? CW : COORD_PORT_WIDTH;
  localparam int MW  = CW + 1;
  localparam int SQW = 2 * MW;
  localparam int EW  = (SQW > DIST_WIDTH) ? SQW : DIST_WIDTH;

  // port coordinate to store width: low bits, or zero-extended when wider
  function automatic logic [CW-1:0] to_coord(input logic [COORD_PORT_WIDTH-1:0] raw);
    logic [RW-1:0] ext;
    ext = RW'(raw);
    return ext[CW-1:0];
  endfunction

  function automatic logic [MW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [MW-1:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    return d[MW-1] ? (~d + MW'(1)) : d;
  endfunction

  function automatic logic [DIST_WIDTH-1:0] sat_sq(input logic [SQW-1:0] s);
    logic [EW-1:0] se;
    se = EW'(s);
    return (se > EW'(DIST_MAX)) ? DIST_MAX : se[DIST_WIDTH-1:0];
  endfunction

  function automatic logic [DIST_WIDTH-1:0] sat_add(input logic [DIST_WIDTH-1:0] a,
                                                    input logic [DIST_WIDTH-1:0] b);
    logic [DIST_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_WIDTH] ? DIST_MAX : s[DIST_WIDTH-1:0];
  endfunction

  logic [CW-1:0]         qx, qy, qz;
  logic [3*CW-1:0]       wr_data, rd_data;
  logic [AW-1:0]         wr_addr;
  logic [31:0]           wr_index_wide;

  // pipeline valid, first and index tags
  logic                  v1, v2, v3, v4, v5;
  logic                  f1, f2, f3, f4, f5;
  logic [AW-1:0]         i1, i2, i3, i4, i5;
  logic [MW-1:0]         mx, my, mz;
  logic [DIST_WIDTH-1:0] sx, sy, sz;
  logic [DIST_WIDTH-1:0] sum_xy, sz_d, dist_total;
  logic [DIST_WIDTH-1:0] best_dist;
  logic [AW-1:0]         best_idx;
  logic [31:0]           best_idx_wide;

  assign wr_index_wide = 32'(request.vertex_index);
  assign wr_addr       = AW'(wr_index_wide);
  assign wr_data       = {to_coord(request.coord_x), to_coord(request.coord_y),
                          to_coord(request.coord_z)};

  nvs_ram #(
    .WIDTH(3 * CW),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (cmd.write_vertex),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (cmd.read_vertex),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= cmd.read_vertex;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end

    if (cmd.load_query) begin
      qx <= to_coord(request.coord_x);
      qy <= to_coord(request.coord_y);
      qz <= to_coord(request.coord_z);
    end

    f1 <= cmd.read_first;
    i1 <= rd_addr;
    f2 <= f1;
    i2 <= i1;
    f3 <= f2;
    i3 <= i2;
    f4 <= f3;
    i4 <= i3;
    f5 <= f4;
    i5 <= i4;

    // magnitudes of the differences
    mx <= abs_diff(qx, rd_data[3*CW-1:2*CW]);
    my <= abs_diff(qy, rd_data[2*CW-1:CW]);
    mz <= abs_diff(qz, rd_data[CW-1:0]);

    // squares
    sx <= sat_sq(mx * mx);
    sy <= sat_sq(my * my);
    sz <= sat_sq(mz * mz);

    // two-step saturating sum
    sum_xy     <= sat_add(sx, sy);
    sz_d       <= sz;
    dist_total <= sat_add(sum_xy, sz_d);

    // strict compare keeps the lowest index on ties
    if (v5 && (f5 || (dist_total < best_dist))) begin
      best_dist <= dist_total;
      best_idx  <= i5;
    end
  end

  assign status.pipe_empty          = !(v1 || v2 || v3 || v4 || v5);
  assign best_idx_wide              = 32'(best_idx);
  assign result.nearest_index       = best_idx_wide[INDEX_WIDTH-1:0];
  assign result.nearest_distance_sq = best_dist;

endmodule

`default_nettype wire
